/* design/cmc_pkg.sv */
`default_nettype none

package cmc_pkg;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;

   localparam int CHAN_W    = 8;
   localparam int COORD_W   = 10;
   localparam int CNT_W     = 21;
   localparam int SUM_W     = 30;
   localparam int CSR_W     = 8;
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = 3;

   // mean of 10-bit coordinates never exceeds 10 bits
   localparam int QUO_W  = COORD_W;
   localparam int STEP_W = $clog2(QUO_W);

   localparam logic [CNT_W-1:0] HIT_CAP = 21'd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_A_LOW  = 3'd0,
      CSR_HUE_A_HIGH = 3'd1,
      CSR_HUE_B_LOW  = 3'd2,
      CSR_HUE_B_HIGH = 3'd3,
      CSR_SAT_LOW    = 3'd4,
      CSR_SAT_HIGH   = 3'd5,
      CSR_VAL_LOW    = 3'd6,
      CSR_VAL_HIGH   = 3'd7
   } csr_index_type;

   localparam logic [NUM_CSR-1:0][CSR_W-1:0] CSR_RESET = {
      8'd255, 8'd100, 8'd255, 8'd100, 8'd179, 8'd160, 8'd10, 8'd0
   };

   typedef struct packed {
      logic [CHAN_W-1:0]  hue;
      logic [CHAN_W-1:0]  sat;
      logic [CHAN_W-1:0]  val;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last_pixel;
   } req_word_type;

   typedef struct packed {
      logic [CNT_W-1:0]   mask_count;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_HOLD
   } cmc_state_type;

   typedef struct packed {
      logic accum;
      logic finish;
      logic div_step;
      logic load_rsp;
   } cmc_cmd_type;

   typedef struct packed {
      logic div_last;
   } cmc_status_type;

endpackage

`default_nettype wire

/* design/cmc_datapath.sv */
`default_nettype none

module cmc_datapath import cmc_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write_en,
   input  wire csr_index_type  csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire req_word_type   req_data,
   input  wire cmc_cmd_type    cmd,
   output cmc_status_type      status,
   output rsp_word_type        rsp_data
);

   function automatic logic in_range(input logic [CHAN_W-1:0] x,
                                     input logic [CHAN_W-1:0] lo,
                                     input logic [CHAN_W-1:0] hi);
      return (x >= lo) && (x <= hi);
   endfunction

   logic [NUM_CSR-1:0][CSR_W-1:0] csr_ff;

   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic [SUM_W-1:0] sum_y_ff, sum_y_in;

   logic [SUM_W-1:0]  rem_x_ff, rem_y_ff, dvs_ff;
   logic [QUO_W-1:0]  quo_x_ff, quo_y_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  cnt_fin_ff;
   rsp_word_type      rsp_data_ff;

   logic hue_ok, hit, take, ge_x, ge_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_write_en) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      hue_ok = in_range(req_data.hue, csr_ff[CSR_HUE_A_LOW], csr_ff[CSR_HUE_A_HIGH]) ||
               in_range(req_data.hue, csr_ff[CSR_HUE_B_LOW], csr_ff[CSR_HUE_B_HIGH]);
      hit = hue_ok &&
            in_range(req_data.sat, csr_ff[CSR_SAT_LOW], csr_ff[CSR_SAT_HIGH]) &&
            in_range(req_data.val, csr_ff[CSR_VAL_LOW], csr_ff[CSR_VAL_HIGH]) &&
            (32'(req_data.col) < 32'(MAX_COLS)) &&
            (32'(req_data.row) < 32'(MAX_ROWS));
      take = cmd.accum && hit && (hit_cnt_ff < HIT_CAP);
      hit_cnt_in = hit_cnt_ff + CNT_W'(take);
      sum_x_in = sum_x_ff + (take ? SUM_W'(req_data.col) : '0);
      sum_y_in = sum_y_ff + (take ? SUM_W'(req_data.row) : '0);
      ge_x = rem_x_ff >= dvs_ff;
      ge_y = rem_y_ff >= dvs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         hit_cnt_ff <= '0;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
      end else if (cmd.accum) begin
         hit_cnt_ff <= hit_cnt_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
      end
   end

   // restoring divide, one quotient bit per step for both axes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.finish) begin
         step_ff <= STEP_W'(QUO_W - 1);
      end else if (cmd.div_step) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rem_x_ff   <= sum_x_in;
         rem_y_ff   <= sum_y_in;
         dvs_ff     <= SUM_W'(hit_cnt_in) << (QUO_W - 1);
         cnt_fin_ff <= hit_cnt_in;
         quo_x_ff   <= '0;
         quo_y_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_x_ff <= ge_x ? rem_x_ff - dvs_ff : rem_x_ff;
         rem_y_ff <= ge_y ? rem_y_ff - dvs_ff : rem_y_ff;
         quo_x_ff <= {quo_x_ff[QUO_W-2:0], ge_x};
         quo_y_ff <= {quo_y_ff[QUO_W-2:0], ge_y};
         dvs_ff   <= dvs_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.mask_count <= cnt_fin_ff;
         rsp_data_ff.center_x   <= (cnt_fin_ff == '0) ? '0 : quo_x_ff;
         rsp_data_ff.center_y   <= (cnt_fin_ff == '0) ? '0 : quo_y_ff;
      end
   end

   assign status.div_last = (step_ff == '0);
   assign rsp_data        = rsp_data_ff;

   a_cap_held: assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= HIT_CAP)
      else $error("hit count above cap");

   a_clear_on_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (hit_cnt_ff == '0) && (sum_x_ff == '0) && (sum_y_ff == '0))
      else $error("accumulators not cleared after frame end");

endmodule

`default_nettype wire

/* design/cmc_ctrl.sv */
`default_nettype none

module cmc_ctrl import cmc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output cmc_cmd_type         cmd,
   input  wire cmc_status_type status
);

   cmc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_stall  = 1'b0;
            cmd.accum  = req_valid;
            cmd.finish = req_valid && req_last;
            if (cmd.finish) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result word raised outside hold");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_DIVIDE) && !status.div_last)
      else $error("divider not started after frame end");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && status.div_last |=> state_ff == ST_HOLD)
      else $error("divider did not finish");

endmodule

`default_nettype wire

/* design/color_mask_centroid.sv */
`default_nettype none

// HSV color mask counter and centroid. Pixels are taken one per clock while a
// frame streams in; each pixel whose hue falls in either hue window and whose
// sat and val lie within bounds (and whose position is inside the frame) is
// counted and its column and row summed. When the last pixel is taken the
// input stalls while the shared restoring divider yields one quotient bit
// per cycle for both axes, then while the result moves to the output
// register. The stall lasts longer only while the prior frame's result word
// is still held there. Empty mask gives count 0 and centroid (0,0). The user
// must have registers written via the csr port only when idle; not enforced.

module color_mask_centroid import cmc_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_word_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_data,
   input  wire logic             csr_write_en,
   input  wire csr_index_type    csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   cmc_cmd_type    cmd;
   cmc_status_type status;

   cmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_pixel),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cmc_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire
